// ----- hw/rtl/epbb_pkg.sv -----
// shared types, register indexes and constants of the encoder position drive
`timescale 1ns / 1ps
`default_nettype none

package epbb_pkg;

	// field widths
	localparam int GEAR_W     = 10;
	localparam int LIMIT_W    = 11;
	localparam int BAND_W     = 7;
	localparam int ANGLE_W    = 8;
	localparam int POS_OUT_W  = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// signed width of products of the gear ratio with a degree value
	localparam int PROD_W = 23;

	localparam int COUNT_WIDTH_DEFAULT = 32;

	// register reset values
	localparam logic [GEAR_W-1:0]  GEAR_RESET  = 10'd100;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd720;
	localparam logic [BAND_W-1:0]  BAND_RESET  = 7'd3;

	// derived thresholds that match the register reset values
	localparam logic signed [PROD_W-1:0] LIM_LO_RESET  = 23'sd72000;
	localparam logic signed [PROD_W-1:0] LIM_HI_RESET  = 23'sd72099;
	localparam logic signed [PROD_W-1:0] HOME_HI_RESET = 23'sd99;
	localparam logic signed [PROD_W-1:0] BAND_G_RESET  = 23'sd300;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GEAR_RATIO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_DEG  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 2'd2;

	// motor command codes
	typedef enum logic [1:0] {
		DRIVE_STOP = 2'd0,
		DRIVE_CW   = 2'd1,
		DRIVE_CCW  = 2'd2
	} drive_t;

	// one sample transaction
	typedef struct packed {
		logic               enc_a;
		logic               enc_b;
		logic               target_valid;
		logic [ANGLE_W-1:0] target_angle;
	} in_item_t;

	// one result transaction
	typedef struct packed {
		drive_t                        drive;
		logic signed [POS_OUT_W-1:0]   position_count;
		logic                          returning_home;
		logic [ANGLE_W-1:0]            target_degrees;
	} out_item_t;

	// thresholds worked out from the configuration registers
	typedef struct packed {
		logic signed [PROD_W-1:0] lim_lo;
		logic signed [PROD_W-1:0] lim_hi;
		logic signed [PROD_W-1:0] home_hi;
		logic signed [PROD_W-1:0] band_g;
	} cfg_derived_t;

endpackage

`default_nettype wire

// ----- hw/rtl/epbb_cfg.sv -----
// configuration registers and the count thresholds derived from them
`timescale 1ns / 1ps
`default_nettype none

module epbb_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	input  wire logic [epbb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [epbb_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic [epbb_pkg::GEAR_W-1:0]           gear_eff,
	output epbb_pkg::cfg_derived_t                derived
);

	logic [epbb_pkg::GEAR_W-1:0]  gear_q;
	logic [epbb_pkg::LIMIT_W-1:0] limit_q;
	logic [epbb_pkg::BAND_W-1:0]  band_q;

	logic [epbb_pkg::GEAR_W+epbb_pkg::LIMIT_W-1:0] lim_prod;
	logic [epbb_pkg::GEAR_W+epbb_pkg::BAND_W-1:0]  band_prod;
	logic signed [epbb_pkg::PROD_W-1:0]           g_minus1;
	epbb_pkg::cfg_derived_t                       derived_d;
	epbb_pkg::cfg_derived_t                       derived_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_q  <= epbb_pkg::GEAR_RESET;
			limit_q <= epbb_pkg::LIMIT_RESET;
			band_q  <= epbb_pkg::BAND_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				epbb_pkg::REG_GEAR_RATIO: gear_q  <= cfg_data[epbb_pkg::GEAR_W-1:0];
				epbb_pkg::REG_LIMIT_DEG:  limit_q <= cfg_data[epbb_pkg::LIMIT_W-1:0];
				epbb_pkg::REG_DEADBAND:   band_q  <= cfg_data[epbb_pkg::BAND_W-1:0];
				default: ;
			endcase
		end
	end

	// a zero gear ratio behaves as one
	assign gear_eff = (gear_q == '0) ? epbb_pkg::GEAR_W'(1) : gear_q;

	// limit window [q*g, q*g+g-1], widened to -(g-1) for a zero limit
	always_comb begin
		lim_prod  = (epbb_pkg::GEAR_W+epbb_pkg::LIMIT_W)'(gear_eff)
			* (epbb_pkg::GEAR_W+epbb_pkg::LIMIT_W)'(limit_q);
		band_prod = (epbb_pkg::GEAR_W+epbb_pkg::BAND_W)'(gear_eff)
			* (epbb_pkg::GEAR_W+epbb_pkg::BAND_W)'(band_q);
		g_minus1  = epbb_pkg::PROD_W'(gear_eff) - epbb_pkg::PROD_W'(1);
		derived_d.home_hi = g_minus1;
		derived_d.band_g  = epbb_pkg::PROD_W'(band_prod);
		derived_d.lim_hi  = epbb_pkg::PROD_W'(lim_prod) + g_minus1;
		derived_d.lim_lo  = (limit_q == '0) ? -g_minus1 : epbb_pkg::PROD_W'(lim_prod);
	end

	// thresholds are registered again behind the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			derived_q.lim_lo  <= epbb_pkg::LIM_LO_RESET;
			derived_q.lim_hi  <= epbb_pkg::LIM_HI_RESET;
			derived_q.home_hi <= epbb_pkg::HOME_HI_RESET;
			derived_q.band_g  <= epbb_pkg::BAND_G_RESET;
		end else begin
			derived_q <= derived_d;
		end
	end

	assign derived = derived_q;

endmodule

`default_nettype wire

// ----- hw/rtl/encoder_position_bang_bang_drive_core.sv -----
// top level: quadrature position count, return-home sequencing and deadband drive
`timescale 1ns / 1ps
`default_nettype none

// Takes one encoder sample per transaction and returns one result per sample. A sample
// passes through an input register, where the new target angle is multiplied by the gear
// ratio, and then through the position, homing and drive logic into the output register.
// A new sample can be accepted every cycle while the output is not stalled; the rate is
// set by the position update, which must finish before the next sample. A configuration
// write is taken every cycle; the thresholds derived from it are registered behind the
// configuration registers. The position count is held in COUNT_WIDTH bits, saturates at
// the signed range, and the result carries its low 32 bits.
module encoder_position_bang_bang_drive_core #(
	parameter int COUNT_WIDTH = epbb_pkg::COUNT_WIDTH_DEFAULT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire epbb_pkg::in_item_t               in_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output epbb_pkg::out_item_t                   out_data,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [epbb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [epbb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CMP_W = ((COUNT_WIDTH > epbb_pkg::POS_OUT_W) ? COUNT_WIDTH
		: epbb_pkg::POS_OUT_W) + 2;
	localparam logic signed [COUNT_WIDTH-1:0] POS_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] POS_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	logic [epbb_pkg::GEAR_W-1:0] gear_eff;
	epbb_pkg::cfg_derived_t      derived;

	// input stage
	logic                               valid_s1;
	epbb_pkg::in_item_t                 item_s1;
	logic signed [epbb_pkg::PROD_W-1:0] ta_g_s1;

	// tracking state
	logic                               last_a_q;
	logic                               last_b_q;
	logic signed [COUNT_WIDTH-1:0]      pos_q;
	logic                               homing_q;
	logic [epbb_pkg::ANGLE_W-1:0]       hold_q;
	logic signed [epbb_pkg::PROD_W-1:0] tpos_q;

	// output stage
	logic                               out_valid_q;
	epbb_pkg::out_item_t                out_q;

	logic                               advance;
	logic                               step_up;
	logic                               step_dn;
	logic signed [COUNT_WIDTH-1:0]      pos_new;
	logic signed [CMP_W-1:0]            pos_x;
	logic                               in_limit;
	logic                               in_home;
	logic                               home_start;
	logic                               homing_mid;
	logic                               homing_new;
	logic [epbb_pkg::ANGLE_W-1:0]       hold_new;
	logic signed [epbb_pkg::PROD_W-1:0] tpos_new;
	logic signed [CMP_W-1:0]            t_lo;
	logic signed [CMP_W-1:0]            t_hi;
	epbb_pkg::out_item_t                out_d;
	logic [epbb_pkg::GEAR_W+epbb_pkg::ANGLE_W-1:0] ta_prod;
	logic [epbb_pkg::GEAR_W+epbb_pkg::ANGLE_W-1:0] hold_prod;

	epbb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.gear_eff  (gear_eff),
		.derived   (derived)
	);

	assign cfg_ready = 1'b1;

	// handshake: the input stage drains whenever the output register is free or emptying
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign ta_prod   = (epbb_pkg::GEAR_W+epbb_pkg::ANGLE_W)'(gear_eff)
		* (epbb_pkg::GEAR_W+epbb_pkg::ANGLE_W)'(in_data.target_angle);
	assign hold_prod = (epbb_pkg::GEAR_W+epbb_pkg::ANGLE_W)'(gear_eff)
		* (epbb_pkg::GEAR_W+epbb_pkg::ANGLE_W)'(hold_q);

	// input register with the new target already scaled to counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
			ta_g_s1 <= epbb_pkg::PROD_W'(ta_prod);
		end
	end

	// quadrature decode, a rising edge on both channels cancels out
	always_comb begin
		step_up = (item_s1.enc_a && !last_a_q && !item_s1.enc_b)
			|| (item_s1.enc_b && !last_b_q && item_s1.enc_a);
		step_dn = (item_s1.enc_a && !last_a_q && item_s1.enc_b)
			|| (item_s1.enc_b && !last_b_q && !item_s1.enc_a);
		if (step_up && !step_dn && pos_q != POS_MAX) begin
			pos_new = pos_q + COUNT_WIDTH'(1);
		end else if (step_dn && !step_up && pos_q != POS_MIN) begin
			pos_new = pos_q - COUNT_WIDTH'(1);
		end else begin
			pos_new = pos_q;
		end
		pos_x = CMP_W'(pos_new);
	end

	// return-home sequencing, targets are ignored while homing
	always_comb begin
		in_limit   = (pos_x >= CMP_W'(derived.lim_lo)) && (pos_x <= CMP_W'(derived.lim_hi));
		in_home    = (pos_x >= CMP_W'(-derived.home_hi)) && (pos_x <= CMP_W'(derived.home_hi));
		home_start = !homing_q && in_limit;
		homing_mid = homing_q || home_start;
		homing_new = homing_mid && !in_home;
		if (home_start || (homing_mid && in_home)) begin
			hold_new = '0;
			tpos_new = '0;
		end else if (item_s1.target_valid && !homing_mid) begin
			hold_new = item_s1.target_angle;
			tpos_new = ta_g_s1;
		end else begin
			hold_new = hold_q;
			tpos_new = tpos_q;
		end
	end

	// deadband drive decision
	always_comb begin
		t_lo = CMP_W'(tpos_new) - CMP_W'(derived.band_g);
		t_hi = CMP_W'(tpos_new) + CMP_W'(derived.band_g);
		if (pos_x < t_lo) begin
			out_d.drive = epbb_pkg::DRIVE_CW;
		end else if (pos_x > t_hi) begin
			out_d.drive = epbb_pkg::DRIVE_CCW;
		end else begin
			out_d.drive = epbb_pkg::DRIVE_STOP;
		end
		out_d.position_count = pos_x[epbb_pkg::POS_OUT_W-1:0];
		out_d.returning_home = homing_new;
		out_d.target_degrees = hold_new;
	end

	// tracking state, target product refreshed between transactions after a ratio change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q <= 1'b1;
			last_b_q <= 1'b1;
			pos_q    <= '0;
			homing_q <= 1'b0;
			hold_q   <= '0;
			tpos_q   <= '0;
		end else if (advance) begin
			last_a_q <= item_s1.enc_a;
			last_b_q <= item_s1.enc_b;
			pos_q    <= pos_new;
			homing_q <= homing_new;
			hold_q   <= hold_new;
			tpos_q   <= tpos_new;
		end else begin
			tpos_q   <= epbb_pkg::PROD_W'(hold_prod);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// the home sequence always runs towards a zero target
	assert property (@(posedge clk) disable iff (!arst_n)
		homing_q |-> (hold_q == '0))
		else $error("homing with a non-zero target");

	// the count moves by at most one per transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (pos_q == $past(pos_q)) || (pos_q == $past(pos_q) + COUNT_WIDTH'(1))
			|| (pos_q == $past(pos_q) - COUNT_WIDTH'(1)))
		else $error("position jumped by more than one count");

	// a stalled input stage keeps its transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a stalled transaction");

	// the target product tracks the held target between transactions
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> (tpos_q == $past(epbb_pkg::PROD_W'(hold_prod))))
		else $error("target product out of step with held target");

endmodule

`default_nettype wire
